FILE: src/current_band_monitor_with_alarm_assert.svh
// assertion macros shared by the current band monitor sources
`ifndef CURRENT_BAND_MONITOR_WITH_ALARM_ASSERT_SVH
`define CURRENT_BAND_MONITOR_WITH_ALARM_ASSERT_SVH
`ifndef ASSERT_OFF
`define CBM_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("cbm assertion failed: invariant");
`define CBM_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbm assertion failed: same-cycle implication");
`define CBM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbm assertion failed: next-cycle implication");
`else
`define CBM_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define CBM_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define CBM_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/cbm_pkg.sv
// shared widths, constants and types of the current band monitor
`default_nettype none
package cbm_pkg;

   localparam int RawWidth      = 10;
   localparam int SelWidth      = 2;
   localparam int CurWidth      = 12;
   localparam int SetpointWidth = 12;
   localparam int NumSetpoints  = 4;
   localparam int ProdWidth     = RawWidth + CurWidth;
   localparam int CmpWidth      = SetpointWidth + 2;

   localparam int ScaleMul   = 3464;
   localparam int ScaleDiv   = 1023;
   localparam int ScaleShift = 10;
   localparam int CurMax     = 3464;
   localparam int BandStep   = 200;

   typedef logic [SetpointWidth-1:0] setpoint_type;
   typedef setpoint_type setpoint_array_type [NumSetpoints];

   localparam setpoint_array_type SetpointReset = '{
      SetpointWidth'(1400), SetpointWidth'(1600),
      SetpointWidth'(1800), SetpointWidth'(2000)
   };

   typedef struct packed {
      logic low;
      logic below_normal;
      logic normal;
      logic above_normal;
      logic high;
   } lamps_type;

   typedef struct packed {
      lamps_type lamps;
      logic      over;
   } band_type;

   typedef struct packed {
      logic fire;
      logic over;
   } alarm_ctrl_type;

endpackage
`default_nettype wire

FILE: src/cbm_if.sv
// request and response channel interfaces of the current band monitor
`default_nettype none
interface cbm_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] raw_sample;
   logic [1:0] setpoint_select;

   modport source (output valid, output raw_sample, output setpoint_select, input ready);
   modport sink (input valid, input raw_sample, input setpoint_select, output ready);
endinterface

interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] scaled_current;
   logic        lamp_low;
   logic        lamp_below_normal;
   logic        lamp_normal;
   logic        lamp_above_normal;
   logic        lamp_high;
   logic        alarm_output;

   modport source (output valid, output scaled_current, output lamp_low,
                   output lamp_below_normal, output lamp_normal,
                   output lamp_above_normal, output lamp_high,
                   output alarm_output, input ready);
   modport sink (input valid, input scaled_current, input lamp_low,
                 input lamp_below_normal, input lamp_normal,
                 input lamp_above_normal, input lamp_high,
                 input alarm_output, output ready);
endinterface
`default_nettype wire

FILE: src/current_band_monitor_with_alarm.sv
// top level of the current band monitor with blinking alarm
`default_nettype none
`include "current_band_monitor_with_alarm_assert.svh"
// a request is registered in the request register, then in the response register;
// one request per cycle while the response side keeps taking its results
// the setpoint read, scaling multiply with reciprocal divide and the band compares
// sit between the two registers; a waiting response stalls requests once both are full
// reset (synchronous, active high) empties both stages, clears tick counter and
// alarm, and loads setpoints 1400, 1600, 1800 and 2000
module current_band_monitor_with_alarm #(
   parameter int TICKS_PER_TOGGLE = 1000
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   cbm_req_if.sink                                 req_chan,
   cbm_rsp_if.source                               rsp_chan,
   input  wire logic                               csr_wr_en,
   input  wire logic [cbm_pkg::SelWidth-1:0]       csr_index,
   input  wire logic [cbm_pkg::SetpointWidth-1:0]  csr_wr_data
);
   import cbm_pkg::*;

   // setpoint registers
   setpoint_type setpoint_ff [NumSetpoints];

   // request stage
   logic                 s1_valid_ff;
   logic [RawWidth-1:0]  s1_raw_ff;
   logic [SelWidth-1:0]  s1_sel_ff;

   // response stage
   logic                 rsp_valid_ff;
   logic [CurWidth-1:0]  rsp_cur_ff;
   lamps_type            rsp_lamps_ff;
   logic                 rsp_alarm_ff;

   logic                 rsp_free;
   logic                 advance;
   logic [CurWidth-1:0]  cur;
   band_type             band;
   alarm_ctrl_type       alarm_ctrl;
   logic                 level_new;

   // handshake: response register frees when empty or being taken
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && rsp_free;
   assign req_chan.ready = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumSetpoints; i++) begin
            setpoint_ff[i] <= SetpointReset[i];
         end
      end else if (csr_wr_en) begin
         setpoint_ff[csr_index] <= csr_wr_data;
      end
   end

   // datapath
   cbm_scale u_scale (
      .raw (s1_raw_ff),
      .cur (cur)
   );

   cbm_classify u_classify (
      .cur      (cur),
      .setpoint (setpoint_ff[s1_sel_ff]),
      .band     (band)
   );

   assign alarm_ctrl.fire = advance;
   assign alarm_ctrl.over = band.over;

   cbm_alarm #(
      .TICKS_PER_TOGGLE (TICKS_PER_TOGGLE)
   ) u_alarm (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (alarm_ctrl),
      .level_new (level_new)
   );

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (rsp_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_raw_ff <= req_chan.raw_sample;
         s1_sel_ff <= req_chan.setpoint_select;
      end
      if (advance) begin
         rsp_cur_ff   <= cur;
         rsp_lamps_ff <= band.lamps;
         rsp_alarm_ff <= level_new;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.scaled_current    = rsp_cur_ff;
   assign rsp_chan.lamp_low          = rsp_lamps_ff.low;
   assign rsp_chan.lamp_below_normal = rsp_lamps_ff.below_normal;
   assign rsp_chan.lamp_normal       = rsp_lamps_ff.normal;
   assign rsp_chan.lamp_above_normal = rsp_lamps_ff.above_normal;
   assign rsp_chan.lamp_high         = rsp_lamps_ff.high;
   assign rsp_chan.alarm_output      = rsp_alarm_ff;

   // bands never overlap
   `CBM_ASSERT_IMPL(a_one_lamp, clock, reset, rsp_valid_ff, $onehot0(rsp_lamps_ff))
   // a blinking alarm means the current is past every band
   `CBM_ASSERT_IMPL(a_alarm_no_lamp, clock, reset, rsp_valid_ff && rsp_alarm_ff,
      rsp_lamps_ff == '0)
   `CBM_ASSERT_IMPL(a_cur_range, clock, reset, rsp_valid_ff,
      rsp_cur_ff <= CurWidth'(CurMax))

endmodule
`default_nettype wire

FILE: src/cbm_scale.sv
// converter sample to tenths of amperes, sample*3464/1023 truncated
`default_nettype none
module cbm_scale (
   input  wire logic [cbm_pkg::RawWidth-1:0] raw,
   output logic [cbm_pkg::CurWidth-1:0]      cur
);
   import cbm_pkg::*;

   logic [ProdWidth-1:0] prod;
   logic [ProdWidth:0]   sum;
   logic [CurWidth-1:0]  quot_est;
   logic [ProdWidth-1:0] back;
   logic [ProdWidth-1:0] rem;

   // x/1023 ~ (x + x/1024)/1024, never above the true quotient and at most one short
   assign prod     = ProdWidth'(raw) * ProdWidth'(ScaleMul);
   assign sum      = (ProdWidth+1)'(prod) + (ProdWidth+1)'(prod >> ScaleShift);
   assign quot_est = CurWidth'(sum >> ScaleShift);
   assign back     = (ProdWidth'(quot_est) << ScaleShift) - ProdWidth'(quot_est);
   assign rem      = prod - back;
   assign cur      = (rem >= ProdWidth'(ScaleDiv)) ? quot_est + CurWidth'(1) : quot_est;

endmodule
`default_nettype wire

FILE: src/cbm_classify.sv
// band lamps and over-limit flag against the selected setpoint
`default_nettype none
module cbm_classify (
   input  wire logic [cbm_pkg::CurWidth-1:0]      cur,
   input  wire logic [cbm_pkg::SetpointWidth-1:0] setpoint,
   output cbm_pkg::band_type                      band
);
   import cbm_pkg::*;

   localparam logic signed [CmpWidth-1:0] Step1 = CmpWidth'(BandStep);
   localparam logic signed [CmpWidth-1:0] Step2 = CmpWidth'(2 * BandStep);
   localparam logic signed [CmpWidth-1:0] Step3 = CmpWidth'(3 * BandStep);

   logic signed [CmpWidth-1:0] cur_s;
   logic signed [CmpWidth-1:0] sp_s;
   logic signed [CmpWidth-1:0] lim_m1;
   logic signed [CmpWidth-1:0] lim_p1;
   logic signed [CmpWidth-1:0] lim_p2;
   logic signed [CmpWidth-1:0] lim_p3;

   // limits are signed: setpoint minus one step may go negative
   assign cur_s  = signed'(CmpWidth'(cur));
   assign sp_s   = signed'(CmpWidth'(setpoint));
   assign lim_m1 = sp_s - Step1;
   assign lim_p1 = sp_s + Step1;
   assign lim_p2 = sp_s + Step2;
   assign lim_p3 = sp_s + Step3;

   assign band.lamps.low          = cur_s < lim_m1;
   assign band.lamps.below_normal = (cur_s >= lim_m1) && (cur_s < sp_s);
   assign band.lamps.normal       = (cur_s >= sp_s) && (cur_s < lim_p1);
   // the upper edge of the normal band lights nothing
   assign band.lamps.above_normal = (cur_s > lim_p1) && (cur_s < lim_p2);
   assign band.lamps.high         = (cur_s >= lim_p2) && (cur_s < lim_p3);
   assign band.over               = cur_s > lim_p3;

endmodule
`default_nettype wire

FILE: src/cbm_alarm.sv
// tick counter and blinking alarm state
`default_nettype none
`include "current_band_monitor_with_alarm_assert.svh"
module cbm_alarm #(
   parameter int TICKS_PER_TOGGLE = 1000
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cbm_pkg::alarm_ctrl_type ctrl,
   output logic                         level_new
);
   import cbm_pkg::*;

   localparam int TickWidth = $clog2(TICKS_PER_TOGGLE);

   logic [TickWidth-1:0] tick_ff;
   logic [TickWidth-1:0] tick_in;
   logic [TickWidth:0]   tick_inc;
   logic                 wrap;
   logic                 active_ff;
   logic                 active_in;
   logic                 level_ff;
   logic                 level_tick;
   logic                 active_new;

   assign tick_inc   = (TickWidth+1)'(tick_ff) + (TickWidth+1)'(1);
   assign wrap       = tick_inc >= (TickWidth+1)'(TICKS_PER_TOGGLE);
   assign level_tick = (wrap && active_ff) ? ~level_ff : level_ff;

   // alarm follows the counter update, then this request's current
   always_comb begin
      priority if (ctrl.over) begin
         active_new = 1'b1;
         level_new  = level_tick;
      end else if (active_ff) begin
         active_new = 1'b0;
         level_new  = 1'b0;
      end else begin
         active_new = 1'b0;
         level_new  = level_tick;
      end
   end

   always_comb begin
      tick_in   = tick_ff;
      active_in = active_ff;
      if (ctrl.fire) begin
         tick_in   = wrap ? '0 : tick_inc[TickWidth-1:0];
         active_in = active_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff   <= '0;
         active_ff <= 1'b0;
         level_ff  <= 1'b0;
      end else begin
         tick_ff   <= tick_in;
         active_ff <= active_in;
         if (ctrl.fire) begin
            level_ff <= level_new;
         end
      end
   end

   `CBM_ASSERT_IMPL(a_level_needs_active, clock, reset, level_ff, active_ff)
   `CBM_ASSERT_ALWAYS(a_tick_in_range, clock, reset,
      (TickWidth+1)'(tick_ff) < (TickWidth+1)'(TICKS_PER_TOGGLE))
   `CBM_ASSERT_NEXT(a_clear_on_drop, clock, reset, ctrl.fire && !ctrl.over,
      !active_ff && !level_ff)

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench of the current band monitor with blinking alarm
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import cbm_pkg::*;

   // same toggle period as the block's default
   localparam int TicksPerToggle = 1000;
   // cycles with no handshake on either channel before the run is abandoned
   localparam int StallLimit     = 2000;
   // random requests per setpoint phase
   localparam int PhaseLength    = 210;
   localparam int NumPhases      = 5;

   // what one response carries, lamps grouped as in the package
   typedef struct packed {
      logic [CurWidth-1:0] current;
      lamps_type           lamps;
      logic                alarm;
   } panel_reading_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [SelWidth-1:0] csr_index;
   logic [SetpointWidth-1:0] csr_wr_data;

   cbm_req_if req_chan ();
   cbm_rsp_if rsp_chan ();

   current_band_monitor_with_alarm #(
      .TICKS_PER_TOGGLE(TicksPerToggle)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // the testbench's own copy of the block's state and registers
   setpoint_type setpoint_regs [NumSetpoints];
   int           tick_count;
   logic         alarm_active;
   logic         alarm_level;

   // readings predicted for accepted requests, oldest first
   panel_reading_type expected_readings [$];
   panel_reading_type arrived_want;

   int  mismatch_count = 0;
   int  requests_sent = 0;
   int  responses_checked = 0;
   int  blink_on_seen = 0;
   int  phases_run = 0;
   int  idle_cycles = 0;
   // when set, neither side inserts gaps or stalls
   bit  no_gaps = 1'b0;

   // current in tenths of amperes for one converter reading, truncated
   function automatic int current_of(input int raw);
      return (raw * ScaleMul) / ScaleDiv;
   endfunction

   // smallest converter reading whose current reaches the target
   function automatic int raw_for_current(input int target);
      for (int r = 0; r < (1 << RawWidth); r++)
         if (current_of(r) >= target) return r;
      return (1 << RawWidth) - 1;
   endfunction

   // advance the state by one request and work out its reading
   function automatic panel_reading_type predict_panel(input logic [RawWidth-1:0] raw,
                                                       input logic [SelWidth-1:0] sel);
      panel_reading_type r;
      int s;
      int cur;
      s = int'(setpoint_regs[sel]);
      // tick first: the toggle uses the alarm state left by earlier requests
      tick_count++;
      if (tick_count >= TicksPerToggle) begin
         tick_count = 0;
         if (alarm_active) alarm_level = !alarm_level;
      end
      cur = current_of(int'(raw));
      r.current            = cur[CurWidth-1:0];
      // limits are signed, so a setpoint under the band step never lights the low lamp
      r.lamps.low          = cur < s - BandStep;
      r.lamps.below_normal = cur >= s - BandStep && cur < s;
      r.lamps.normal       = cur >= s && cur < s + BandStep;
      // exactly one band step above the setpoint lights nothing
      r.lamps.above_normal = cur > s + BandStep && cur < s + 2 * BandStep;
      r.lamps.high         = cur >= s + 2 * BandStep && cur < s + 3 * BandStep;
      if (cur > s + 3 * BandStep) begin
         alarm_active = 1'b1;
      end else if (alarm_active) begin
         // leaving the alarm band forces the drive low at once
         alarm_active = 1'b0;
         alarm_level  = 1'b0;
      end
      r.alarm = alarm_level;
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // one request: optional gaps, then hold valid until it is taken
   task automatic send_reading_request(input int raw, input int sel);
      panel_reading_type want;
      while (!no_gaps && $urandom_range(0, 99) < 20) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.raw_sample      <= raw[RawWidth-1:0];
      req_chan.setpoint_select <= sel[SelWidth-1:0];
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // valid is left high so back-to-back requests carry no bubble
      want = predict_panel(raw[RawWidth-1:0], sel[SelWidth-1:0]);
      if (want.alarm) blink_on_seen++;
      expected_readings.push_back(want);
      requests_sent++;
   endtask

   // stop sending and let every outstanding response come back
   task automatic drain_requests();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
      // two register stages of latency, plus margin
      repeat (4) @(posedge clock);
   endtask

   // load all four setpoints while the block is idle
   task automatic program_setpoints(input setpoint_type vals [NumSetpoints]);
      drain_requests();
      for (int i = 0; i < NumSetpoints; i++) begin
         csr_wr_en   <= 1'b1;
         csr_index   <= SelWidth'(i);
         csr_wr_data <= vals[i];
         @(posedge clock);
         setpoint_regs[i] = vals[i];
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
      phases_run++;
   endtask

   // a request that drives the current over the alarm limit of some setpoint, or a random one if none leaves room
   task automatic pick_over_range(output int raw, output int sel);
      int first;
      int s;
      first = $urandom_range(0, NumSetpoints - 1);
      raw = $urandom_range(0, (1 << RawWidth) - 1);
      sel = first;
      for (int k = 0; k < NumSetpoints; k++) begin
         s = int'(setpoint_regs[(first + k) % NumSetpoints]);
         if (s + 3 * BandStep < CurMax) begin
            sel = (first + k) % NumSetpoints;
            raw = $urandom_range(raw_for_current(s + 3 * BandStep + 1), (1 << RawWidth) - 1);
            return;
         end
      end
   endtask

   // reset setpoints, both ends of the converter range on every select,
   // alarm raised and cleared in turn
   task automatic test_reset_defaults();
      for (int sel = 0; sel < NumSetpoints; sel++) begin
         send_reading_request((1 << RawWidth) - 1, sel);
         send_reading_request(0, sel);
      end
   endtask

   // setpoints placed so one reading lands exactly on each band limit
   task automatic test_band_edges();
      setpoint_type vals [NumSetpoints];
      int c;
      c = current_of(500);
      // on the setpoint, one step under, two steps under, three steps under
      vals = '{SetpointWidth'(c), SetpointWidth'(c - BandStep),
               SetpointWidth'(c - 2 * BandStep), SetpointWidth'(c - 3 * BandStep)};
      program_setpoints(vals);
      for (int sel = 0; sel < NumSetpoints; sel++) begin
         send_reading_request(500, sel);
         send_reading_request(499, sel);
      end
      // both limits of the below-normal band, just under it, and just under the alarm limit
      vals = '{SetpointWidth'(c + BandStep), SetpointWidth'(c + 1),
               SetpointWidth'(c + BandStep + 1), SetpointWidth'(c - 3 * BandStep + 1)};
      program_setpoints(vals);
      for (int sel = 0; sel < NumSetpoints; sel++) send_reading_request(500, sel);
   endtask

   // setpoints at zero, just under the band step, the band step and full scale
   task automatic test_setpoint_extremes();
      setpoint_type vals [NumSetpoints];
      vals = '{SetpointWidth'(0), SetpointWidth'(BandStep - 1),
               {SetpointWidth{1'b1}}, SetpointWidth'(BandStep)};
      program_setpoints(vals);
      send_reading_request(0, 0);
      send_reading_request(0, 1);
      send_reading_request((1 << RawWidth) - 1, 2);
      send_reading_request((1 << RawWidth) - 1, 3);
   endtask

   // random traffic over several setpoint phases, mostly aimed at band limits;
   // around each tick wrap the requests stay in the alarm band so the drive blinks
   task automatic test_random_traffic();
      setpoint_type vals [NumSetpoints];
      int raw;
      int sel;
      int s;
      int target;
      int pick;
      int slot;
      for (int p = 0; p < NumPhases; p++) begin
         case (p)
            0: vals = SetpointReset;
            1: vals = '{{SetpointWidth{1'b1}}, SetpointWidth'(0),
                        SetpointWidth'(BandStep - 1), SetpointWidth'(BandStep)};
            4: vals = '{SetpointWidth'(BandStep), SetpointWidth'(CurMax - 3 * BandStep - 1),
                        {SetpointWidth{1'b1}}, SetpointWidth'($urandom_range(0, 4095))};
            default: begin
               // keep one setpoint low enough for the alarm band to exist
               vals[0] = SetpointWidth'($urandom_range(0, 2800));
               for (int i = 1; i < NumSetpoints; i++)
                  vals[i] = SetpointWidth'($urandom_range(0, 4095));
            end
         endcase
         program_setpoints(vals);
         for (int n = 0; n < PhaseLength; n++) begin
            // a long stretch without gaps or stalls in the middle phase
            no_gaps = (p == 2) && (n < 150);
            slot = requests_sent % TicksPerToggle;
            pick = $urandom_range(0, 99);
            if (slot >= TicksPerToggle - 40 || slot < 20) begin
               pick_over_range(raw, sel);
            end else if (pick < 15) begin
               raw = $urandom_range(0, (1 << RawWidth) - 1);
               sel = $urandom_range(0, NumSetpoints - 1);
            end else if (pick < 80) begin
               sel = $urandom_range(0, NumSetpoints - 1);
               s = int'(setpoint_regs[sel]);
               target = s + BandStep * (int'($urandom_range(0, 4)) - 1)
                        + int'($urandom_range(0, 6)) - 3;
               if (target < 0) target = 0;
               if (target > CurMax) target = CurMax;
               raw = raw_for_current(target);
            end else begin
               pick_over_range(raw, sel);
            end
            send_reading_request(raw, sel);
         end
         no_gaps = 1'b0;
      end
   endtask

   // response side: ready stalls at random unless gaps are off
   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= no_gaps || ($urandom_range(0, 99) >= 20);
   end

   // compare each response taken with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_readings.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            arrived_want = expected_readings.pop_front();
            check_field("scaled_current", int'(arrived_want.current),
                        int'(rsp_chan.scaled_current));
            check_field("lamp_low", int'(arrived_want.lamps.low), int'(rsp_chan.lamp_low));
            check_field("lamp_below_normal", int'(arrived_want.lamps.below_normal),
                        int'(rsp_chan.lamp_below_normal));
            check_field("lamp_normal", int'(arrived_want.lamps.normal),
                        int'(rsp_chan.lamp_normal));
            check_field("lamp_above_normal", int'(arrived_want.lamps.above_normal),
                        int'(rsp_chan.lamp_above_normal));
            check_field("lamp_high", int'(arrived_want.lamps.high), int'(rsp_chan.lamp_high));
            check_field("alarm_output", int'(arrived_want.alarm),
                        int'(rsp_chan.alarm_output));
            responses_checked++;
         end
      end
   end

   // watchdog: abandon the run after a long spell with no handshake at all
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
         $display("timeout: %0d responses still outstanding", expected_readings.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset                    <= 1'b1;
      csr_wr_en                <= 1'b0;
      csr_index                <= '0;
      csr_wr_data              <= '0;
      req_chan.valid           <= 1'b0;
      req_chan.raw_sample      <= '0;
      req_chan.setpoint_select <= '0;
      setpoint_regs = SetpointReset;
      tick_count    = 0;
      alarm_active  = 1'b0;
      alarm_level   = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_band_edges();
      test_setpoint_extremes();
      test_random_traffic();

      drain_requests();
      $display("%0d requests sent, %0d responses checked over %0d setpoint phases",
               requests_sent, responses_checked, phases_run);
      $display("%0d responses with the alarm drive high, %0d mismatches",
               blink_on_seen, mismatch_count);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire
